FILE: rtl/twl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twl_pkg
// Shared types and constants for the two-wire handshake byte link.
// ----------------------------------------------------------------------------
package twl_pkg;

  // configuration field width and reset value of the wait limit
  localparam int CFG_TIMEOUT_W      = 24;
  localparam int TIMEOUT_RESET      = 100000;
  localparam int TIMEOUT_WIDTH_DFLT = 24;

  // stream payload widths
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  // request kinds
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SEND = 2'd1,
    REQ_RECV = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // completion status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SND_TO = 2'd1,
    ST_RCV_TO = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  // link phase
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_TX_ACK   = 4'd1,
    PH_TX_REL   = 4'd2,
    PH_RX_START = 4'd3,
    PH_RX_REL   = 4'd4
  } phase_t;

  // line drive codes, a 0 bit pulls that line low
  localparam logic [1:0] DRV_RELEASE = 2'b11;
  localparam logic [1:0] DRV_LINE1   = 2'b01;
  localparam logic [1:0] DRV_LINE0   = 2'b10;

  // one request as held in the input register
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] tx_byte;
    logic [1:0] lines_in;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [1:0] lines_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] status;
  } result_t;

endpackage

FILE: rtl/twl_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twl_in_stage
// Input register: captures one request and holds it until the core steps.
// ----------------------------------------------------------------------------
module twl_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  twl_pkg::in_item_t  s_item,
  input  logic               take,
  output logic               in_valid,
  output twl_pkg::in_item_t  in_item
);
  import twl_pkg::*;

  // ready when empty or when the held request moves on this cycle
  assign s_tready = !in_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_item;
    end
  end

endmodule

FILE: rtl/twl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twl_core
// Link state machine: one step per request, bit send/receive with timeouts.
// ----------------------------------------------------------------------------
module twl_core #(
  parameter int TIMEOUT_WIDTH = twl_pkg::TIMEOUT_WIDTH_DFLT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  twl_pkg::in_item_t        item,
  input  logic [TIMEOUT_WIDTH-1:0] timeout,
  output twl_pkg::result_t         result
);
  import twl_pkg::*;

  phase_t                   phase, phase_next;
  logic [2:0]               bit_index, bit_index_next;
  logic [7:0]               shift_reg, shift_reg_next;
  logic [TIMEOUT_WIDTH-1:0] wait_count, wait_count_next;
  logic [1:0]               line_drive, line_drive_next;
  logic                     bit_value, bit_value_next;

  logic [TIMEOUT_WIDTH-1:0] cnt_inc, cnt_sat;
  logic                     timed_out;
  logic [1:0]               tx_watch, rx_watch;
  logic                     tx_low, tx_high, rx_seen, rx_high, last_bit;
  logic                     rx_bit;

  // saturating wait counter and timeout compare
  assign cnt_inc   = wait_count + TIMEOUT_WIDTH'(1);
  assign cnt_sat   = (cnt_inc == '0) ? '1 : cnt_inc;
  assign timed_out = (cnt_sat >= timeout);

  // watched lines and line conditions
  assign tx_watch = bit_value ? DRV_LINE1 : DRV_LINE0;
  assign rx_watch = bit_value ? DRV_LINE0 : DRV_LINE1;
  assign tx_low   = ((item.lines_in & tx_watch) == 2'b00);
  assign tx_high  = !tx_low;
  assign rx_seen  = (item.lines_in != DRV_RELEASE);
  assign rx_high  = ((item.lines_in & rx_watch) != 2'b00);
  assign rx_bit   = (item.lines_in == DRV_LINE1);
  assign last_bit = &bit_index;

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (item.req_type == REQ_SEND) begin
          phase_next = PH_TX_ACK;
        end else if (item.req_type == REQ_RECV) begin
          phase_next = PH_RX_START;
        end
      end
      PH_TX_ACK: begin
        if (tx_low) begin
          phase_next = PH_TX_REL;
        end else if (timed_out) begin
          phase_next = PH_IDLE;
        end
      end
      PH_TX_REL: begin
        if (tx_high) begin
          phase_next = last_bit ? PH_IDLE : PH_TX_ACK;
        end else if (timed_out) begin
          phase_next = PH_IDLE;
        end
      end
      PH_RX_START: begin
        if (rx_seen) begin
          phase_next = PH_RX_REL;
        end else if (timed_out) begin
          phase_next = PH_IDLE;
        end
      end
      PH_RX_REL: begin
        if (rx_high) begin
          phase_next = last_bit ? PH_IDLE : PH_RX_START;
        end else if (timed_out) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // datapath and result outputs
  always_comb begin
    bit_index_next  = bit_index;
    shift_reg_next  = shift_reg;
    wait_count_next = wait_count;
    line_drive_next = line_drive;
    bit_value_next  = bit_value;
    result.done_res = 1'b0;
    result.status   = ST_OK;
    result.rx_byte  = 8'h00;
    unique case (phase)
      PH_IDLE: begin
        if (item.req_type == REQ_SEND) begin
          shift_reg_next  = item.tx_byte;
          bit_index_next  = 3'd0;
          bit_value_next  = item.tx_byte[0];
          line_drive_next = item.tx_byte[0] ? DRV_LINE1 : DRV_LINE0;
          wait_count_next = '0;
        end else if (item.req_type == REQ_RECV) begin
          shift_reg_next  = 8'h00;
          bit_index_next  = 3'd0;
          wait_count_next = '0;
          line_drive_next = DRV_RELEASE;
        end
      end
      PH_TX_ACK: begin
        if (tx_low) begin
          line_drive_next = DRV_RELEASE;
          wait_count_next = '0;
        end else begin
          wait_count_next = cnt_sat;
          if (timed_out) begin
            line_drive_next = DRV_RELEASE;
            result.done_res = 1'b1;
            result.status   = ST_SND_TO;
          end
        end
      end
      PH_TX_REL: begin
        if (tx_high) begin
          if (last_bit) begin
            result.done_res = 1'b1;
          end else begin
            // shift out the next bit and drive it
            bit_index_next  = bit_index + 3'd1;
            shift_reg_next  = {1'b0, shift_reg[7:1]};
            bit_value_next  = shift_reg[1];
            line_drive_next = shift_reg[1] ? DRV_LINE1 : DRV_LINE0;
            wait_count_next = '0;
          end
        end else begin
          wait_count_next = cnt_sat;
          if (timed_out) begin
            line_drive_next = DRV_RELEASE;
            result.done_res = 1'b1;
            result.status   = ST_SND_TO;
          end
        end
      end
      PH_RX_START: begin
        if (rx_seen) begin
          // sample the bit and acknowledge on the other line
          bit_value_next  = rx_bit;
          shift_reg_next  = {rx_bit, shift_reg[7:1]};
          line_drive_next = rx_bit ? DRV_LINE0 : DRV_LINE1;
          wait_count_next = '0;
        end else begin
          wait_count_next = cnt_sat;
          if (timed_out) begin
            line_drive_next = DRV_RELEASE;
            result.done_res = 1'b1;
            result.status   = ST_RCV_TO;
          end
        end
      end
      PH_RX_REL: begin
        if (rx_high) begin
          line_drive_next = DRV_RELEASE;
          wait_count_next = '0;
          if (last_bit) begin
            result.done_res = 1'b1;
            result.rx_byte  = shift_reg;
          end else begin
            bit_index_next = bit_index + 3'd1;
          end
        end else begin
          wait_count_next = cnt_sat;
          if (timed_out) begin
            line_drive_next = DRV_RELEASE;
            result.done_res = 1'b1;
            result.status   = ST_RCV_TO;
          end
        end
      end
      default: begin
        line_drive_next = DRV_RELEASE;
        wait_count_next = '0;
      end
    endcase
    result.lines_out = line_drive_next;
    result.busy_res  = (phase_next != PH_IDLE);
  end

  // state registers, advance once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= 3'd0;
      shift_reg  <= 8'h00;
      wait_count <= '0;
      line_drive <= DRV_RELEASE;
      bit_value  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      shift_reg  <= shift_reg_next;
      wait_count <= wait_count_next;
      line_drive <= line_drive_next;
      bit_value  <= bit_value_next;
    end
  end

endmodule

FILE: rtl/two_wire_handshake_byte_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wire_handshake_byte_link
// Byte link over two open-drain wires with a per-bit handshake and timeouts.
// ----------------------------------------------------------------------------
// Each request is one tick of the link: it carries the sampled wire levels
// and optionally a command to start sending or receiving a byte (LSB first).
// Every request yields exactly one result with the new wire drive, busy,
// done, the received byte and a status. One request is taken per clock cycle
// in steady state while results are taken; a request is held in the input
// register, the link state machine steps once as it moves on, and its result
// is held in the result register. The result register lets a new request in
// while an earlier result still waits to be taken.
// The wait limit (timeout_ticks) is written through cfg_we/cfg_wdata and
// counts requests, not clock cycles; the user must write it only while
// the link is idle, which the block itself does not enforce.
module two_wire_handshake_byte_link #(
  parameter int TIMEOUT_WIDTH = twl_pkg::TIMEOUT_WIDTH_DFLT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [twl_pkg::CFG_TIMEOUT_W-1:0] cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tx_byte[7:0], lines_in[9:8], zero[15:10]
  input  logic [twl_pkg::S_TDATA_W-1:0]     s_tdata,
  // req_type[1:0]
  input  logic [twl_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // lines_out[1:0], busy_res[2], done_res[3], rx_byte[11:4], status[13:12],
  // zero[15:14]
  output logic [twl_pkg::M_TDATA_W-1:0]     m_tdata
);
  import twl_pkg::*;

  logic [TIMEOUT_WIDTH-1:0] timeout_ticks;
  in_item_t                 s_item, in_item;
  logic                     in_valid, advance;
  result_t                  core_res, out_res;

  // wait limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_WIDTH'(TIMEOUT_RESET);
    end else if (cfg_we) begin
      timeout_ticks <= TIMEOUT_WIDTH'(cfg_wdata);
    end
  end

  // unpack the request
  always_comb begin
    s_item.req_type = s_tuser;
    s_item.tx_byte  = s_tdata[7:0];
    s_item.lines_in = s_tdata[9:8];
  end

  // held request moves on when the result register is free
  assign advance = in_valid && (!m_tvalid || m_tready);

  twl_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (s_item),
    .take     (advance),
    .in_valid (in_valid),
    .in_item  (in_item)
  );

  twl_core #(
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (in_item),
    .timeout (timeout_ticks),
    .result  (core_res)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  // pack the result
  assign m_tdata = {2'b00, out_res.status, out_res.rx_byte, out_res.done_res,
                    out_res.busy_res, out_res.lines_out};

  // a finished transfer never reports busy
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("done reported while still busy");

  // an error status only comes with done
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[13:12] != 2'd0) |-> m_tdata[3])
    else $error("status set without done");

  // a received byte only shows on a successful done
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:4] != 8'h00) |-> m_tdata[3] && (m_tdata[13:12] == 2'd0))
    else $error("received byte outside a good done");

  // when idle both lines are released
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> (m_tdata[1:0] == 2'b11))
    else $error("lines driven while idle");

endmodule
